[hw/rtl/ryb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryb_pkg
// Shared defaults and the RYB cube corner table.
// ----------------------------------------------------------------------------
package ryb_pkg;

  localparam int AMOUNT_WIDTH_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int CH_NUM            = 3;
  localparam int CORNER_NUM        = 8;

  // corner components in thousandths, index r | y<<1 | b<<2
  function automatic logic [63:0] corner_milli(input int idx, input int ch);
    logic [63:0] k;
    k = 64'd0;
    case (idx)
      0: k = (ch == 0) ? 64'd1000 : (ch == 1) ? 64'd1000 : 64'd1000;
      1: k = (ch == 0) ? 64'd1000 : 64'd0;
      2: k = (ch == 2) ? 64'd0    : 64'd1000;
      3: k = (ch == 0) ? 64'd1000 : (ch == 1) ? 64'd500 : 64'd0;
      4: k = (ch == 0) ? 64'd163  : (ch == 1) ? 64'd373 : 64'd600;
      5: k = (ch == 1) ? 64'd0    : 64'd500;
      6: k = (ch == 0) ? 64'd0    : (ch == 1) ? 64'd660 : 64'd200;
      7: k = (ch == 0) ? 64'd200  : (ch == 1) ? 64'd94  : 64'd0;
      default: k = 64'd0;
    endcase
    return k;
  endfunction

  // corner colour in Q8.F, rounded half up
  function automatic logic [63:0] corner_scaled(input int idx, input int ch, input int fb);
    logic [63:0] k;
    k = corner_milli(idx, ch);
    return (((k * 64'd255) << fb) + 64'd500) / 64'd1000;
  endfunction

endpackage

[hw/rtl/ryb_amounts_to_rgb_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryb_amounts_to_rgb_core
// RYB pigment amounts to an 8-bit RGB colour, fully pipelined.
// ----------------------------------------------------------------------------
// Each item carries three pigment amounts. The block normalizes them to the
// largest one (Q1.F weights, every amount equal to the largest gets exactly
// 1.0, all-zero gives the all-pigment corner) and trilinearly blends the
// eight RYB cube corners per channel, each channel rounded half up. One item
// enters per clock while the pipeline advances. The input register feeds the
// restoring divider, one quotient bit per stage, then three multiply/add blend
// levels. The whole pipeline advances when the output register is empty or
// being taken, so a stall holds every stage and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module ryb_amounts_to_rgb_core
  import ryb_pkg::*;
#(
  parameter int AMOUNT_WIDTH  = AMOUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int IN_W = ((3 * AMOUNT_WIDTH + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // red_amount, yellow_amount, blue_amount, zero fill
  input  logic [IN_W-1:0] in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  // red_out, green_out, blue_out
  output logic [23:0]     out_tdata
);

  localparam int AW   = AMOUNT_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int VW   = 8 + F;          // Q8.F corner / blend value
  localparam int WW   = F + 1;          // Q1.F weight
  localparam int PW   = VW + F + 1;     // product / sum width
  localparam int NS   = F + 9;          // stage count
  localparam logic [WW-1:0] ONE  = WW'(1) << F;
  localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

  logic          adv;
  logic [NS-1:0] vld_r;

  assign adv        = !vld_r[NS-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_tvalid};
    end
  end

  // input stage
  logic [AW-1:0] a_r [CH_NUM];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < CH_NUM; c++) begin
        a_r[c] <= in_tdata[c*AW +: AW];
      end
    end
  end

  // maximum; amounts at the maximum (or all zero) bypass the divider
  logic [AW-1:0] mx;
  always_comb begin
    mx = a_r[0];
    if (a_r[1] >= mx) mx = a_r[1];
    if (a_r[2] >= mx) mx = a_r[2];
  end

  logic [AW-1:0] d_rem_r [F][CH_NUM];
  logic [F-1:0]  d_q_r   [F+1][CH_NUM];
  logic          d_one_r [F+1][CH_NUM];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < CH_NUM; c++) begin
        d_rem_r[0][c] <= (a_r[c] == mx) ? '0 : a_r[c];
        d_q_r[0][c]   <= '0;
        d_one_r[0][c] <= (a_r[c] == mx);
      end
    end
  end

  logic [AW-1:0] d_max_r [F];
  always_ff @(posedge clk) begin
    if (adv) d_max_r[0] <= mx;
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < F; k++) begin : g_div
    if (k < F - 1) begin : g_mx
      always_ff @(posedge clk) begin
        if (adv) d_max_r[k+1] <= d_max_r[k];
      end
    end
    for (genvar c = 0; c < CH_NUM; c++) begin : g_ch
      logic [AW:0] r2;
      logic        ge;
      assign r2 = {d_rem_r[k][c], 1'b0};
      assign ge = (r2 >= {1'b0, d_max_r[k]});
      if (k < F - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (adv) begin
            d_rem_r[k+1][c] <= ge ? AW'(r2 - {1'b0, d_max_r[k]}) : AW'(r2);
          end
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          d_q_r[k+1][c]   <= {d_q_r[k][c][F-2:0], ge};
          d_one_r[k+1][c] <= d_one_r[k][c];
        end
      end
    end
  end

  logic [WW-1:0] w [CH_NUM];
  for (genvar c = 0; c < CH_NUM; c++) begin : g_w
    assign w[c] = d_one_r[F][c] ? ONE : {1'b0, d_q_r[F][c]};
  end

  // blend levels: red, then yellow, then blue
  logic [PW-1:0] m1a_r [CH_NUM][4];
  logic [PW-1:0] m1b_r [CH_NUM][4];
  logic [VW-1:0] e_r   [CH_NUM][4];
  logic [PW-1:0] m2a_r [CH_NUM][2];
  logic [PW-1:0] m2b_r [CH_NUM][2];
  logic [VW-1:0] f_r   [CH_NUM][2];
  logic [PW-1:0] m3a_r [CH_NUM];
  logic [PW-1:0] m3b_r [CH_NUM];
  logic [VW-1:0] v_r   [CH_NUM];
  logic [7:0]    o_r   [CH_NUM];
  logic [WW-1:0] m1_wy_r, m1_wb_r, s1_wy_r, s1_wb_r, m2_wb_r, s2_wb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_wy_r <= w[1];
      m1_wb_r <= w[2];
      s1_wy_r <= m1_wy_r;
      s1_wb_r <= m1_wb_r;
      m2_wb_r <= s1_wb_r;
      s2_wb_r <= m2_wb_r;
    end
  end

  for (genvar c = 0; c < CH_NUM; c++) begin : g_bl
    for (genvar e = 0; e < 4; e++) begin : g_e
      localparam logic [VW-1:0] LO = VW'(corner_scaled(2*e, c, F));
      localparam logic [VW-1:0] HI = VW'(corner_scaled(2*e+1, c, F));
      logic [PW-1:0] s;
      assign s = m1a_r[c][e] + m1b_r[c][e] + HALF;
      always_ff @(posedge clk) begin
        if (adv) begin
          m1a_r[c][e] <= PW'(LO) * PW'(ONE - w[0]);
          m1b_r[c][e] <= PW'(HI) * PW'(w[0]);
          e_r[c][e]   <= s[F +: VW];
        end
      end
    end
    for (genvar g = 0; g < 2; g++) begin : g_f
      logic [PW-1:0] s;
      assign s = m2a_r[c][g] + m2b_r[c][g] + HALF;
      always_ff @(posedge clk) begin
        if (adv) begin
          m2a_r[c][g] <= PW'(e_r[c][2*g]) * PW'(ONE - s1_wy_r);
          m2b_r[c][g] <= PW'(e_r[c][2*g+1]) * PW'(s1_wy_r);
          f_r[c][g]   <= s[F +: VW];
        end
      end
    end
    logic [PW-1:0] s3;
    logic [VW:0]   cv;
    assign s3 = m3a_r[c] + m3b_r[c] + HALF;
    assign cv = {1'b0, v_r[c]} + (VW+1)'(HALF);
    always_ff @(posedge clk) begin
      if (adv) begin
        m3a_r[c] <= PW'(f_r[c][0]) * PW'(ONE - s2_wb_r);
        m3b_r[c] <= PW'(f_r[c][1]) * PW'(s2_wb_r);
        v_r[c]   <= s3[F +: VW];
        o_r[c]   <= (cv[VW:F] > 9'd255) ? 8'd255 : cv[F +: 8];
      end
    end
  end

  assign out_tdata = {o_r[2], o_r[1], o_r[0]};

endmodule

[hw/rtl/ryb_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ryb_chk
// Port-level checks for ryb_amounts_to_rgb_core.
// ----------------------------------------------------------------------------
module ryb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready not tied to output side");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output item changed");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

endmodule

bind ryb_amounts_to_rgb_core ryb_chk u_ryb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
